FILE: hw/rtl/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// constants, types and round functions for the sha-256 stream hasher
// ----------------------------------------------------------------------------
package shs_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LengthPos  = 56;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_ROUND [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_ADD   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  typedef enum logic {
    REQ_APPEND = 1'b0,
    REQ_FINISH = 1'b1
  } req_t;

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic logic [31:0] ch(input logic [31:0] e, input logic [31:0] f,
                                     input logic [31:0] g);
    ch = (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] maj(input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] c);
    maj = (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

FILE: hw/rtl/sha256_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit
// byte-serial sha-256: gathers bytes into a 512-bit block line, compresses
// with one round unit used 64 times, pads on finish and emits the digest
// ----------------------------------------------------------------------------
//  channel | signals                                   | role
//  --------+-------------------------------------------+---------------------
//  in      | in_valid, in_ready, req_type, data_byte   | byte or finish item
//  out     | out_valid, out_ready, digest_word,        | eight digest words
//          | word_index, last_word                     | per finish
//
//  an append is taken in the idle state; the 64th byte of a block starts a
//  compression (load, 64 rounds through the single round unit, hash add)
//  a finish shifts in one padding byte per cycle up to the block end, then
//  compresses once or twice, then offers eight words, one per accepted cycle
//  in_ready is low from a block's 64th byte or a finish until the block is idle again
//  rst is synchronous and returns the initial hash values and zero counts
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import shs_pkg::*;

  state_t        state;
  logic [511:0]  blk;
  logic [6:0]    fill;
  logic [60:0]   byte_count;
  logic [63:0]   len_sr;
  logic          pad_mode;
  logic          len_phase;
  logic [5:0]    round;
  logic [2:0]    out_idx;
  logic [31:0]   hash [8];
  logic [31:0]   work [8];

  logic [31:0]   w0;
  logic [31:0]   w_new;
  logic [31:0]   t1;
  logic [31:0]   t2;
  logic [7:0]    pad_byte;
  logic          in_fire;
  logic          out_fire;

  assign in_ready    = (state == ST_IDLE);
  assign out_valid   = (state == ST_OUT);
  assign digest_word = hash[0];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == 3'd7);
  assign in_fire     = in_valid && in_ready;
  assign out_fire    = out_valid && out_ready;

  // message schedule and round unit
  assign w0    = blk[511:480];
  assign w_new = w0 + ssig0(blk[479:448]) + blk[223:192] + ssig1(blk[63:32]);
  assign t1    = work[7] + bsig1(work[4]) + ch(work[4], work[5], work[6])
                 + K_ROUND[round] + w0;
  assign t2    = bsig0(work[0]) + maj(work[0], work[1], work[2]);

  // zeros, then the bit length once the last block is reached
  assign pad_byte = (len_phase && (fill >= 7'(LengthPos))) ? len_sr[63:56] : 8'h00;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill       <= '0;
      byte_count <= '0;
      pad_mode   <= 1'b0;
      len_phase  <= 1'b0;
      round      <= '0;
      out_idx    <= '0;
      hash       <= H_INIT;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            fill <= fill + 7'd1;
            if (req_t'(req_type) == REQ_APPEND) begin
              blk        <= {blk[503:0], data_byte};
              byte_count <= byte_count + 61'd1;
              state      <= (fill == 7'(BlockBytes - 1)) ? ST_LOAD : ST_IDLE;
            end else begin
              blk       <= {blk[503:0], PAD_BYTE};
              len_sr    <= {byte_count, 3'b000};
              pad_mode  <= 1'b1;
              len_phase <= (fill < 7'(LengthPos));
              state     <= (fill == 7'(BlockBytes - 1)) ? ST_LOAD : ST_PAD;
            end
          end
        end
        ST_PAD: begin
          blk  <= {blk[503:0], pad_byte};
          fill <= fill + 7'd1;
          if (len_phase && (fill >= 7'(LengthPos))) begin
            len_sr <= {len_sr[55:0], 8'h00};
          end
          if (fill == 7'(BlockBytes - 1)) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          work  <= hash;
          round <= '0;
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          work[0] <= t1 + t2;
          work[1] <= work[0];
          work[2] <= work[1];
          work[3] <= work[2];
          work[4] <= work[3] + t1;
          work[5] <= work[4];
          work[6] <= work[5];
          work[7] <= work[6];
          blk     <= {blk[479:0], w_new};
          round   <= round + 6'd1;
          if (round == 6'd63) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + work[i];
          end
          fill <= '0;
          if (!pad_mode) begin
            state <= ST_IDLE;
          end else if (len_phase) begin
            out_idx <= '0;
            state   <= ST_OUT;
          end else begin
            len_phase <= 1'b1;
            state     <= ST_PAD;
          end
        end
        ST_OUT: begin
          if (out_fire) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              hash       <= H_INIT;
              byte_count <= '0;
              fill       <= '0;
              pad_mode   <= 1'b0;
              len_phase  <= 1'b0;
              state      <= ST_IDLE;
            end else begin
              for (int i = 0; i < 7; i++) begin
                hash[i] <= hash[i+1];
              end
              hash[7] <= hash[0];
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output sides active together");

  a_full_block: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> (fill == 7'(BlockBytes)))
    else $error("compression started on a partial block");

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && round == 6'd63) |=> (state == ST_ADD))
    else $error("round sequence did not end after 64 rounds");

  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    (out_fire && last_word) |=> in_ready)
    else $error("not idle after the last digest word");

endmodule
